FILE: src/sbf_pkg.sv
// Shared types, constants and helpers for the spring bond force pipeline.
package sbf_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned K_W     = 24;
    localparam int unsigned RHL_W   = 31;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned HALF_W  = 31;
    localparam int unsigned SQ_W    = 64;
    localparam int unsigned ROOT_W  = 32;
    localparam int unsigned SQREM_W = 34;
    localparam int unsigned PROD_W  = 63;
    localparam int unsigned DVREM_W = 33;
    localparam int unsigned FMAG_W  = 40;
    localparam int unsigned N_SQRT  = 32;
    localparam int unsigned N_DIV   = 32;

    localparam logic [IDX_W-1:0] REG_SPRING_CONSTANT  = 8'd0;
    localparam logic [IDX_W-1:0] REG_REST_HALF_LENGTH = 8'd1;

    localparam logic [K_W-1:0]   K_RESET   = 24'd65536;
    localparam logic [RHL_W-1:0] RHL_RESET = 31'd65536;

    localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [HALF_W-1:0] hx;
        logic [HALF_W-1:0] hy;
        logic              nx;
        logic              ny;
    } half_t;

    typedef struct packed {
        half_t              h;
        logic [SQ_W-1:0]    s;
        logic [SQREM_W-1:0] rem;
        logic [ROOT_W-1:0]  root;
    } sq_t;

    typedef struct packed {
        logic [WORD_W-1:0]  num;
        logic [DVREM_W-1:0] rem;
        logic [WORD_W-1:0]  q;
    } lane_t;

    typedef struct packed {
        lane_t             lx;
        lane_t             ly;
        logic [ROOT_W-1:0] r;
        logic              nx;
        logic              ny;
        logic              ne;
        logic              zero;
        logic [WORD_W-1:0] energy;
    } dv_t;

    function automatic logic [WORD_W-1:0] force_of(input logic neg,
                                                   input logic [FMAG_W-1:0] m);
        logic [WORD_W-1:0] res;
        begin
            if (!neg)
                res = (m > FMAG_W'(SAT_POS)) ? SAT_POS : m[WORD_W-1:0];
            else if (m >= FMAG_W'(SAT_NEG))
                res = SAT_NEG;
            else
                res = (~m[WORD_W-1:0]) + WORD_W'(1);
            return res;
        end
    endfunction

endpackage

FILE: src/sbf_if.sv
// Request channel interfaces for bonds, results and configuration writes.
interface sbf_bond_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    modport source (output valid, a_x, a_y, b_x, b_y, input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, output ready);
endinterface

interface sbf_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_a_x;
    logic signed [31:0] force_a_y;
    logic signed [31:0] force_b_x;
    logic signed [31:0] force_b_y;
    logic        [31:0] potential_energy;
    modport source (output valid, force_a_x, force_a_y, force_b_x, force_b_y,
                    potential_energy, input ready);
    modport sink   (input valid, force_a_x, force_a_y, force_b_x, force_b_y,
                    potential_energy, output ready);
endinterface

interface sbf_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/spring_bond_force_2d.sv
// Top level: Hookean spring bond force and energy for two particles in 2D.
//
// A bond request on the bond channel carries the positions of particles A and B
// (signed Q16.16). Each request yields one result request on the result channel:
// the forces on A and B (signed Q16.16, saturated) and the bond energy
// (unsigned Q16.16, saturated). Results leave in request order.
// The path from acceptance to a valid result runs through 2 front stages,
// 32 square root cells (one root bit each), 4 stretch/energy stages,
// 32 divider cells (one quotient bit each) and 2 scaling/saturation stages.
// Throughput is one bond per cycle unless the result channel stalls; every
// stage holds its own valid bit, so bubbles close up and the chain keeps
// accepting while a result waits. A stalled result channel backs the chain
// up stage by stage; bond.ready drops only once the first stage is full and cannot move.
// The cfg channel is always ready: index 0 writes the spring constant
// (Q8.16), index 1 the rest half length (Q15.16); other indexes are dropped.
// Write configuration only while no bond is in flight.
// Reset clears all stage valid bits and loads spring constant 1.0 and rest
// half length 1.0.
module spring_bond_force_2d
    import sbf_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    sbf_bond_if.sink     bond,
    sbf_result_if.source result,
    sbf_cfg_if.sink      cfg
);
    logic [K_W-1:0]   k_reg;
    logic [RHL_W-1:0] rhl_reg;

    logic sq_valid [0:N_SQRT];
    logic sq_ready [0:N_SQRT];
    sq_t  sq_data  [0:N_SQRT];
    logic dv_valid [0:N_DIV];
    logic dv_ready [0:N_DIV];
    dv_t  dv_data  [0:N_DIV];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= K_RESET;
            rhl_reg <= RHL_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SPRING_CONSTANT:  k_reg   <= cfg.data[K_W-1:0];
                REG_REST_HALF_LENGTH: rhl_reg <= cfg.data[RHL_W-1:0];
                default: ;
            endcase
        end
    end

    sbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bond.valid),
        .in_ready  (bond.ready),
        .a_x       (bond.a_x),
        .a_y       (bond.a_y),
        .b_x       (bond.b_x),
        .b_y       (bond.b_y),
        .out_valid (sq_valid[0]),
        .out_ready (sq_ready[0]),
        .out_data  (sq_data[0])
    );

    for (genvar i = 0; i < N_SQRT; i++)
    begin : g_sqrt
        sbf_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .in_data   (sq_data[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .out_data  (sq_data[i+1])
        );
    end

    sbf_mid u_mid (
        .clk              (clk),
        .rst_n            (rst_n),
        .spring_constant  (k_reg),
        .rest_half_length (rhl_reg),
        .in_valid         (sq_valid[N_SQRT]),
        .in_ready         (sq_ready[N_SQRT]),
        .in_data          (sq_data[N_SQRT]),
        .out_valid        (dv_valid[0]),
        .out_ready        (dv_ready[0]),
        .out_data         (dv_data[0])
    );

    for (genvar j = 0; j < N_DIV; j++)
    begin : g_div
        sbf_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[j]),
            .in_ready  (dv_ready[j]),
            .in_data   (dv_data[j]),
            .out_valid (dv_valid[j+1]),
            .out_ready (dv_ready[j+1]),
            .out_data  (dv_data[j+1])
        );
    end

    sbf_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .spring_constant  (k_reg),
        .in_valid         (dv_valid[N_DIV]),
        .in_ready         (dv_ready[N_DIV]),
        .in_data          (dv_data[N_DIV]),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .force_a_x        (result.force_a_x),
        .force_a_y        (result.force_a_y),
        .force_b_x        (result.force_b_x),
        .force_b_y        (result.force_b_y),
        .potential_energy (result.potential_energy)
    );

    a_sym_x: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (32'(result.force_a_x + result.force_b_x) == 32'd0 ||
                          32'(result.force_a_x + result.force_b_x) == 32'hFFFF_FFFF))
        else $error("force x on A and B not opposite");

    a_sym_y: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (32'(result.force_a_y + result.force_b_y) == 32'd0 ||
                          32'(result.force_a_y + result.force_b_y) == 32'hFFFF_FFFF))
        else $error("force y on A and B not opposite");

    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.valid |=> ($stable(k_reg) && $stable(rhl_reg)))
        else $error("config register changed without a write");
endmodule

FILE: src/sbf_front.sv
// Front stages: half separation magnitudes, then squared length.
module sbf_front
    import sbf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    output logic               out_valid,
    input  logic               out_ready,
    output sq_t                out_data
);
    logic        h_valid_reg;
    half_t       h_reg;
    half_t       h_next;
    logic        s_valid_reg;
    sq_t         s_reg;
    sq_t         s_next;
    logic        h_ready;
    logic        s_ready;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] mx;
    logic [32:0] my;

    assign s_ready  = !s_valid_reg || out_ready;
    assign h_ready  = !h_valid_reg || s_ready;
    assign in_ready = h_ready;

    always_comb
    begin
        dx = {b_x[31], b_x} - {a_x[31], a_x};
        dy = {b_y[31], b_y} - {a_y[31], a_y};
        mx = dx[32] ? (~dx + 33'd1) : dx;
        my = dy[32] ? (~dy + 33'd1) : dy;
        h_next.hx = mx[31:1];
        h_next.hy = my[31:1];
        h_next.nx = dx[32];
        h_next.ny = dy[32];
    end

    always_comb
    begin
        s_next.h    = h_reg;
        s_next.s    = SQ_W'(h_reg.hx) * SQ_W'(h_reg.hx) + SQ_W'(h_reg.hy) * SQ_W'(h_reg.hy);
        s_next.rem  = '0;
        s_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (h_ready)
                h_valid_reg <= in_valid;
            if (s_ready)
                s_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_ready && in_valid)
            h_reg <= h_next;
        if (s_ready && h_valid_reg)
            s_reg <= s_next;
    end

    assign out_valid = s_valid_reg;
    assign out_data  = s_reg;
endmodule

FILE: src/sbf_sqrt_cell.sv
// One square root cell: settles one root bit from two radicand bits.
module sbf_sqrt_cell
    import sbf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sq_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output sq_t  out_data
);
    logic               valid_reg;
    sq_t                data_reg;
    sq_t                data_next;
    logic [SQREM_W-1:0] rem2;
    logic [SQREM_W-1:0] trial;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        rem2  = {in_data.rem[SQREM_W-3:0], in_data.s[SQ_W-1:SQ_W-2]};
        trial = {in_data.root, 2'b01};
        data_next   = in_data;
        data_next.s = {in_data.s[SQ_W-3:0], 2'b00};
        if (rem2 >= trial)
        begin
            data_next.rem  = rem2 - trial;
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem2;
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

FILE: src/sbf_mid.sv
// Middle stages: stretch, numerators and squared stretch, energy.
module sbf_mid
    import sbf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [K_W-1:0]   spring_constant,
    input  logic [RHL_W-1:0] rest_half_length,
    input  logic             in_valid,
    output logic             in_ready,
    input  sq_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dv_t              out_data
);
    logic              e_valid_reg, m_valid_reg, k_valid_reg, n_valid_reg;
    logic              e_ready, m_ready, k_ready, n_ready;
    half_t             e_h_reg;
    logic [ROOT_W-1:0] e_r_reg;
    logic [WORD_W-1:0] e_e_reg;
    logic [WORD_W-1:0] e_e_next;
    logic              e_ne_reg;
    logic              e_ne_next;
    logic              e_zero_reg;
    logic [PROD_W-1:0] m_px_reg, m_py_reg;
    logic [63:0]       m_e2_reg;
    logic [ROOT_W-1:0] m_r_reg;
    logic [3:0]        m_flags_reg;
    logic [PROD_W-1:0] k_px_reg, k_py_reg;
    logic [ROOT_W-1:0] k_r_reg;
    logic [3:0]        k_flags_reg;
    logic [55:0]       k_hi_reg;
    logic [55:0]       k_lo_full;
    logic [K_W-1:0]    k_lo_reg;
    dv_t               n_reg;
    dv_t               n_next;
    logic [56:0]       esum;

    assign n_ready  = !n_valid_reg || out_ready;
    assign k_ready  = !k_valid_reg || n_ready;
    assign m_ready  = !m_valid_reg || k_ready;
    assign e_ready  = !e_valid_reg || m_ready;
    assign in_ready = e_ready;

    always_comb
    begin
        e_e_next  = '0;
        e_ne_next = 1'b0;
        if (in_data.root != '0)
        begin
            if (in_data.root >= ROOT_W'(rest_half_length))
                e_e_next = in_data.root - ROOT_W'(rest_half_length);
            else
            begin
                e_e_next  = ROOT_W'(rest_half_length) - in_data.root;
                e_ne_next = 1'b1;
            end
        end
    end

    assign k_lo_full = 56'(spring_constant) * 56'(m_e2_reg[31:0]);

    always_comb
    begin
        esum = 57'(k_hi_reg) + 57'(k_lo_reg);
        n_next.lx.num  = k_px_reg[WORD_W-1:0];
        n_next.lx.rem  = DVREM_W'(k_px_reg[PROD_W-1:WORD_W]);
        n_next.lx.q    = '0;
        n_next.ly.num  = k_py_reg[WORD_W-1:0];
        n_next.ly.rem  = DVREM_W'(k_py_reg[PROD_W-1:WORD_W]);
        n_next.ly.q    = '0;
        n_next.r       = k_r_reg;
        {n_next.nx, n_next.ny, n_next.ne, n_next.zero} = k_flags_reg;
        n_next.energy  = (esum > 57'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : esum[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
            n_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_ready)
                e_valid_reg <= in_valid;
            if (m_ready)
                m_valid_reg <= e_valid_reg;
            if (k_ready)
                k_valid_reg <= m_valid_reg;
            if (n_ready)
                n_valid_reg <= k_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && in_valid)
        begin
            e_h_reg    <= in_data.h;
            e_r_reg    <= in_data.root;
            e_e_reg    <= e_e_next;
            e_ne_reg   <= e_ne_next;
            e_zero_reg <= (in_data.root == '0);
        end
        if (m_ready && e_valid_reg)
        begin
            m_px_reg    <= PROD_W'(e_h_reg.hx) * PROD_W'(e_e_reg);
            m_py_reg    <= PROD_W'(e_h_reg.hy) * PROD_W'(e_e_reg);
            m_e2_reg    <= 64'(e_e_reg) * 64'(e_e_reg);
            m_r_reg     <= e_r_reg;
            m_flags_reg <= {e_h_reg.nx, e_h_reg.ny, e_ne_reg, e_zero_reg};
        end
        if (k_ready && m_valid_reg)
        begin
            k_px_reg    <= m_px_reg;
            k_py_reg    <= m_py_reg;
            k_r_reg     <= m_r_reg;
            k_flags_reg <= m_flags_reg;
            k_hi_reg    <= 56'(spring_constant) * 56'(m_e2_reg[63:32]);
            k_lo_reg    <= k_lo_full[55:32];
        end
        if (n_ready && k_valid_reg)
            n_reg <= n_next;
    end

    assign out_valid = n_valid_reg;
    assign out_data  = n_reg;
endmodule

FILE: src/sbf_div_cell.sv
// One divider cell: settles one quotient bit in each of the two lanes.
module sbf_div_cell
    import sbf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  dv_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output dv_t  out_data
);
    logic valid_reg;
    dv_t  data_reg;
    dv_t  data_next;

    function automatic lane_t step(input lane_t l, input logic [ROOT_W-1:0] r);
        lane_t              o;
        logic [DVREM_W-1:0] rem2;
        begin
            rem2  = {l.rem[DVREM_W-2:0], l.num[WORD_W-1]};
            o.num = {l.num[WORD_W-2:0], 1'b0};
            if (rem2 >= DVREM_W'(r))
            begin
                o.rem = rem2 - DVREM_W'(r);
                o.q   = {l.q[WORD_W-2:0], 1'b1};
            end
            else
            begin
                o.rem = rem2;
                o.q   = {l.q[WORD_W-2:0], 1'b0};
            end
            return o;
        end
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next    = in_data;
        data_next.lx = step(in_data.lx, in_data.r);
        data_next.ly = step(in_data.ly, in_data.r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

FILE: src/sbf_back.sv
// Back stages: scale by stiffness, then saturate into the result register.
module sbf_back
    import sbf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [K_W-1:0]     spring_constant,
    input  logic               in_valid,
    output logic               in_ready,
    input  dv_t                in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] force_a_x,
    output logic signed [31:0] force_a_y,
    output logic signed [31:0] force_b_x,
    output logic signed [31:0] force_b_y,
    output logic        [31:0] potential_energy
);
    logic              p_valid_reg, o_valid_reg;
    logic              p_ready, o_ready;
    logic [WORD_W-1:0] ddx, ddy;
    logic [55:0]       px_full, py_full;
    logic [FMAG_W-1:0] p_mx_reg, p_my_reg;
    logic              p_sx_reg, p_sy_reg, p_zx_reg, p_zy_reg;
    logic [WORD_W-1:0] p_energy_reg;
    logic [WORD_W-1:0] fax_reg, fay_reg, fbx_reg, fby_reg, en_reg;

    assign o_ready  = !o_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign in_ready = p_ready;

    assign ddx     = in_data.zero ? '0 : in_data.lx.q;
    assign ddy     = in_data.zero ? '0 : in_data.ly.q;
    assign px_full = 56'(spring_constant) * 56'(ddx);
    assign py_full = 56'(spring_constant) * 56'(ddy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
                p_valid_reg <= in_valid;
            if (o_ready)
                o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && in_valid)
        begin
            p_mx_reg     <= px_full[55:16];
            p_my_reg     <= py_full[55:16];
            p_zx_reg     <= (ddx == '0);
            p_zy_reg     <= (ddy == '0);
            p_sx_reg     <= (in_data.nx != in_data.ne) && (ddx != '0);
            p_sy_reg     <= (in_data.ny != in_data.ne) && (ddy != '0);
            p_energy_reg <= in_data.energy;
        end
        if (o_ready && p_valid_reg)
        begin
            fax_reg <= force_of(p_sx_reg, p_mx_reg);
            fay_reg <= force_of(p_sy_reg, p_my_reg);
            fbx_reg <= force_of(!p_sx_reg && !p_zx_reg, p_mx_reg);
            fby_reg <= force_of(!p_sy_reg && !p_zy_reg, p_my_reg);
            en_reg  <= p_energy_reg;
        end
    end

    assign out_valid        = o_valid_reg;
    assign force_a_x        = fax_reg;
    assign force_a_y        = fay_reg;
    assign force_b_x        = fbx_reg;
    assign force_b_y        = fby_reg;
    assign potential_energy = en_reg;
endmodule

FILE: tb/sv/tb_top.sv
// Testbench for spring_bond_force_2d: directed and random bonds against a bit-exact force and energy predictor.
`timescale 1ns / 100ps

module tb_top;
    import sbf_pkg::*;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] bx;
        logic [31:0] by;
    } bond_t;

    typedef struct packed {
        logic [31:0] fax;
        logic [31:0] fay;
        logic [31:0] fbx;
        logic [31:0] fby;
        logic [31:0] energy;
    } force_t;

    typedef struct packed {
        logic [7:0]  idx;
        logic [31:0] data;
    } cfg_t;

    logic clk;
    logic rst_n;

    sbf_bond_if   bond_ch ();
    sbf_result_if res_ch ();
    sbf_cfg_if    cfg_ch ();

    spring_bond_force_2d i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bond   (bond_ch.sink),
        .result (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    bond_t  bond_q[$];
    cfg_t   cfg_q[$];
    force_t force_q[$];
    logic [23:0] k_model;
    logic [30:0] rhl_model;
    int  errors;
    int  cycles;
    bit  calm;
    int  src_gap;
    int  snk_gap;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [63:0] isqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] sat_force(bit neg, logic [63:0] dmag);
        logic [63:0] m;
        m = ({40'd0, k_model} * dmag) >> 16;
        if (!neg)
            return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        if (m >= 64'h8000_0000)
            return 32'h8000_0000;
        return 32'(64'h1_0000_0000 - m);
    endfunction

    function automatic force_t bond_force(bond_t b);
        force_t f;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0] hx;
        logic [63:0] hy;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] ddx;
        logic [63:0] ddy;
        logic [63:0] e2;
        logic [127:0] en;
        bit nx;
        bit ny;
        bit ne;
        bit sx;
        bit sy;
        dx = 64'(signed'(b.bx)) - 64'(signed'(b.ax));
        dy = 64'(signed'(b.by)) - 64'(signed'(b.ay));
        nx = dx < 0;
        ny = dy < 0;
        hx = (nx ? -dx : dx) >> 1;
        hy = (ny ? -dy : dy) >> 1;
        r  = isqrt(hx * hx + hy * hy);
        e = 0;
        ne = 0;
        ddx = 0;
        ddy = 0;
        if (r != 0)
        begin
            if (r >= rhl_model)
                e = r - rhl_model;
            else
            begin
                e  = rhl_model - r;
                ne = 1;
            end
            ddx = (hx * e) / r;
            ddy = (hy * e) / r;
        end
        sx = (nx != ne) && ddx != 0;
        sy = (ny != ne) && ddy != 0;
        f.fax = sat_force(sx, ddx);
        f.fay = sat_force(sy, ddy);
        f.fbx = sat_force(!sx && ddx != 0, ddx);
        f.fby = sat_force(!sy && ddy != 0, ddy);
        e2 = e * e;
        en = k_model * (e2 >> 32) + ((k_model * (e2 & 64'hFFFF_FFFF)) >> 32);
        f.energy = (en > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : en[31:0];
        return f;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'(signed'($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // drive bonds and configuration
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bond_ch.valid <= 1'b0;
            bond_ch.a_x <= '0;
            bond_ch.a_y <= '0;
            bond_ch.b_x <= '0;
            bond_ch.b_y <= '0;
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data <= '0;
            src_gap <= 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == REG_SPRING_CONSTANT)
                    k_model = cfg_ch.data[23:0];
                else if (cfg_ch.index == REG_REST_HALF_LENGTH)
                    rhl_model = cfg_ch.data[30:0];
            end
            if (bond_ch.valid && bond_ch.ready)
                force_q.push_back(bond_force({bond_ch.a_x, bond_ch.a_y,
                                              bond_ch.b_x, bond_ch.b_y}));
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (cfg_q.size() > 0)
                begin
                    cfg_t c;
                    c = cfg_q.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= c.idx;
                    cfg_ch.data <= c.data;
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
            if (!bond_ch.valid || bond_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    bond_ch.valid <= 1'b0;
                end
                else if (bond_q.size() > 0)
                begin
                    bond_t b;
                    b = bond_q.pop_front();
                    bond_ch.valid <= 1'b1;
                    bond_ch.a_x <= b.ax;
                    bond_ch.a_y <= b.ay;
                    bond_ch.b_x <= b.bx;
                    bond_ch.b_y <= b.by;
                    if (!calm && $urandom_range(0, 9) == 0)
                        src_gap <= $urandom_range(1, 6);
                end
                else
                    bond_ch.valid <= 1'b0;
            end
        end
    end

    // check results and stall the result channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            snk_gap <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (force_q.size() == 0)
                    report("unexpected result", res_ch.force_a_x, 32'h0);
                else
                begin
                    force_t w;
                    w = force_q.pop_front();
                    if (res_ch.force_a_x !== w.fax)
                        report("force_a_x", res_ch.force_a_x, w.fax);
                    if (res_ch.force_a_y !== w.fay)
                        report("force_a_y", res_ch.force_a_y, w.fay);
                    if (res_ch.force_b_x !== w.fbx)
                        report("force_b_x", res_ch.force_b_x, w.fbx);
                    if (res_ch.force_b_y !== w.fby)
                        report("force_b_y", res_ch.force_b_y, w.fby);
                    if (res_ch.potential_energy !== w.energy)
                        report("potential_energy", res_ch.potential_energy, w.energy);
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap <= snk_gap - 1;
                res_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                snk_gap <= $urandom_range(0, 5);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic wait_idle();
        while (bond_q.size() > 0 || bond_ch.valid || force_q.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        cfg_q.push_back({idx, data});
        while (cfg_q.size() > 0 || cfg_ch.valid)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic push_bond(logic [31:0] ax, logic [31:0] ay,
                             logic [31:0] bx, logic [31:0] by);
        bond_q.push_back({ax, ay, bx, by});
    endtask

    task automatic random_bonds(int n);
        logic [31:0] ax;
        logic [31:0] ay;
        for (int i = 0; i < n; i++)
        begin
            ax = rand_pos();
            ay = rand_pos();
            if ($urandom_range(0, 9) == 0)
                push_bond(ax, ay, ax, ay);
            else
                push_bond(ax, ay, rand_pos(), rand_pos());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        errors = 0;
        cycles = 0;
        calm = 0;
        k_model = K_RESET;
        rhl_model = RHL_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_bond(0, 0, 0, 0);
        push_bond(0, 0, 32'h0002_0000, 0);
        push_bond(0, 0, 0, 32'h0004_0000);
        push_bond(0, 0, 1, 0);
        push_bond(0, 0, 32'hFFFF_FFFF, 1);
        push_bond(0, 0, 3, 32'hFFFF_FFFD);
        push_bond(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_bond(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        push_bond(32'h0001_0000, 32'h0001_0000, 32'h0001_8000, 32'h0001_8000);
        push_bond(32'hFFFF_0000, 0, 32'h0001_0000, 0);
        wait_idle();

        write_reg(REG_SPRING_CONSTANT, 32'hFFFF_FFFF);
        write_reg(REG_REST_HALF_LENGTH, 32'hFFFF_FFFF);
        write_reg(8'd7, 32'h1234_5678);
        push_bond(0, 0, 0, 0);
        push_bond(0, 0, 32'h0000_0002, 0);
        push_bond(32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
        random_bonds(150);
        wait_idle();

        write_reg(REG_SPRING_CONSTANT, 0);
        write_reg(REG_REST_HALF_LENGTH, 0);
        random_bonds(150);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_SPRING_CONSTANT, $urandom);
            write_reg(REG_REST_HALF_LENGTH, $urandom_range(0, 32'h00FF_FFFF));
            random_bonds(150);
            wait_idle();
        end

        write_reg(REG_SPRING_CONSTANT, 32'h0001_0000);
        write_reg(REG_REST_HALF_LENGTH, 32'h0001_0000);
        calm = 1;
        random_bonds(100);
        wait_idle();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
